>>> rtl/sorted_age_statistics_core_defines.svh
// Assertion macros shared by the sorted age statistics core.
`ifndef SORTED_AGE_STATISTICS_CORE_DEFINES_SVH
`define SORTED_AGE_STATISTICS_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SAS_ASSERT_HOLDS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("sorted_age_statistics_core: check failed");
`define SAS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted_age_statistics_core: check failed");
`else
`define SAS_ASSERT_HOLDS(label, cond)
`define SAS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/sas_pkg.sv
// Shared constants and types of the sorted age statistics core.
package sas_pkg;

    localparam int CAPACITY    = 64;
    localparam int AGE_W       = 8;
    localparam int AGE_MAX     = 255;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int SUM_W       = $clog2(CAPACITY * AGE_MAX + 1);
    localparam int DIV_STEP_W  = $clog2(SUM_W + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [AGE_W-1:0] age_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [SUM_W-1:0] sum_t;

    typedef struct packed {
        age_t age;
        logic final_age;
    } queue_item_t;

    typedef struct packed {
        logic insert;
        logic rotate;
        logic pop;
        age_t key;
    } chain_op_t;

endpackage

>>> rtl/sas_queue.sv
// Input item queue between the accepting front and the sorting back end.
module sas_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  sas_pkg::queue_item_t in_item,
    output logic                 out_valid,
    output sas_pkg::queue_item_t out_item,
    input  logic                 take
);

    sas_pkg::queue_item_t               mem_reg [sas_pkg::QUEUE_DEPTH];
    logic [sas_pkg::QPTR_W-1:0]         wr_ptr_reg;
    logic [sas_pkg::QPTR_W-1:0]         wr_ptr_next;
    logic [sas_pkg::QPTR_W-1:0]         rd_ptr_reg;
    logic [sas_pkg::QPTR_W-1:0]         rd_ptr_next;
    logic [sas_pkg::QLVL_W-1:0]         level_reg;
    logic [sas_pkg::QLVL_W-1:0]         level_next;
    logic                               do_push;
    logic                               do_take;

    assign full      = (level_reg == sas_pkg::QLVL_W'(sas_pkg::QUEUE_DEPTH));
    assign out_valid = (level_reg != '0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_take   = take && out_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == sas_pkg::QPTR_W'(sas_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + sas_pkg::QPTR_W'(1);
        end
        if (do_take)
        begin
            rd_ptr_next = (rd_ptr_reg == sas_pkg::QPTR_W'(sas_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + sas_pkg::QPTR_W'(1);
        end
        if (do_push && !do_take)
        begin
            level_next = level_reg + sas_pkg::QLVL_W'(1);
        end
        else if (!do_push && do_take)
        begin
            level_next = level_reg - sas_pkg::QLVL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

>>> rtl/sas_chain.sv
// Insertion sort chain: ascending cells with valid bits, rotate and pop shifts.
module sas_chain
(
    input  logic                clk,
    input  logic                rst_n,
    input  sas_pkg::chain_op_t  op,
    output sas_pkg::age_t       head_age,
    output logic                head_valid
);

    sas_pkg::age_t  cell_reg   [sas_pkg::CAPACITY];
    sas_pkg::age_t  cell_next  [sas_pkg::CAPACITY];
    logic [sas_pkg::CAPACITY-1:0] valid_reg;
    logic [sas_pkg::CAPACITY-1:0] valid_next;

    assign head_age   = cell_reg[0];
    assign head_valid = valid_reg[0];

    // Empty cells behave as larger than any age, so inserts keep them at the tail.
    always_comb
    begin
        cell_next  = cell_reg;
        valid_next = valid_reg;
        priority if (op.insert)
        begin
            cell_next[0]  = (!valid_reg[0] || cell_reg[0] > op.key) ? op.key : cell_reg[0];
            valid_next[0] = 1'b1;
            for (int i = 1; i < sas_pkg::CAPACITY; i++)
            begin
                if (valid_reg[i-1] && cell_reg[i-1] > op.key)
                begin
                    cell_next[i] = cell_reg[i-1];
                end
                else if (!valid_reg[i] || cell_reg[i] > op.key)
                begin
                    cell_next[i] = op.key;
                end
                else
                begin
                    cell_next[i] = cell_reg[i];
                end
                valid_next[i] = valid_reg[i] || valid_reg[i-1];
            end
        end
        else if (op.rotate || op.pop)
        begin
            for (int i = 0; i < sas_pkg::CAPACITY - 1; i++)
            begin
                cell_next[i]  = cell_reg[i+1];
                valid_next[i] = valid_reg[i+1];
            end
            cell_next[sas_pkg::CAPACITY-1]  = cell_reg[0];
            valid_next[sas_pkg::CAPACITY-1] = op.rotate && valid_reg[0];
        end
        else
        begin
            cell_next  = cell_reg;
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

endmodule

>>> rtl/sas_div.sv
// Restoring divider, one quotient bit per cycle, for the floor mean.
module sas_div
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  sas_pkg::sum_t dividend,
    input  sas_pkg::cnt_t divisor,
    output logic          done,
    output sas_pkg::sum_t quotient
);

    logic                           busy_reg;
    logic                           busy_next;
    logic                           done_reg;
    logic                           done_next;
    logic [sas_pkg::DIV_STEP_W-1:0] step_reg;
    logic [sas_pkg::DIV_STEP_W-1:0] step_next;
    sas_pkg::sum_t                  qr_reg;
    sas_pkg::sum_t                  qr_next;
    sas_pkg::cnt_t                  rem_reg;
    sas_pkg::cnt_t                  rem_next;
    sas_pkg::cnt_t                  divisor_reg;
    sas_pkg::cnt_t                  divisor_next;
    logic [sas_pkg::CNT_W:0]        trial;
    logic [sas_pkg::CNT_W:0]        diff;
    logic                           fits;

    assign done     = done_reg;
    assign quotient = qr_reg;

    // The partial remainder stays below the divisor, so it fits in CNT_W bits.
    assign trial = {rem_reg, qr_reg[sas_pkg::SUM_W-1]};
    assign fits  = (trial >= {1'b0, divisor_reg});
    assign diff  = trial - {1'b0, divisor_reg};

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        step_next    = step_reg;
        qr_next      = qr_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            step_next    = '0;
            qr_next      = dividend;
            rem_next     = '0;
            divisor_next = divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[sas_pkg::CNT_W-1:0] : trial[sas_pkg::CNT_W-1:0];
            qr_next   = {qr_reg[sas_pkg::SUM_W-2:0], fits};
            step_next = step_reg + sas_pkg::DIV_STEP_W'(1);
            if (step_reg == sas_pkg::DIV_STEP_W'(sas_pkg::SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qr_reg      <= qr_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

endmodule

>>> rtl/sas_back.sv
// Back end: loads ages into the sort chain, computes the statistics, emits results.
module sas_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  sas_pkg::queue_item_t q_item,
    output logic                 q_take,
    output logic                 empty,
    input  logic                 pop,
    output sas_pkg::age_t        sorted_age,
    output sas_pkg::age_t        mean_age,
    output sas_pkg::age_t        min_age,
    output sas_pkg::age_t        max_age,
    output sas_pkg::cnt_t        above_count,
    output sas_pkg::cnt_t        below_count,
    output logic                 dropped,
    output logic                 end_of_run
);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_START,
        ST_DIVIDE,
        ST_COUNT,
        ST_EMIT
    } state_t;

    state_t                    state_reg;
    state_t                    state_next;
    sas_pkg::cnt_t             count_reg;
    sas_pkg::cnt_t             count_next;
    sas_pkg::sum_t             sum_reg;
    sas_pkg::sum_t             sum_next;
    logic                      overflow_reg;
    logic                      overflow_next;
    sas_pkg::age_t             min_reg;
    sas_pkg::age_t             min_next;
    sas_pkg::age_t             max_reg;
    sas_pkg::age_t             max_next;
    sas_pkg::age_t             mean_reg;
    sas_pkg::age_t             mean_next;
    sas_pkg::cnt_t             above_reg;
    sas_pkg::cnt_t             above_next;
    sas_pkg::cnt_t             below_reg;
    sas_pkg::cnt_t             below_next;
    logic [sas_pkg::IDX_W-1:0] idx_reg;
    logic [sas_pkg::IDX_W-1:0] idx_next;
    sas_pkg::chain_op_t        op;
    sas_pkg::age_t             head_age;
    logic                      head_valid;
    logic                      div_start;
    logic                      div_done;
    sas_pkg::sum_t             div_quotient;
    logic                      room;

    sas_chain u_chain
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .head_age   (head_age),
        .head_valid (head_valid)
    );

    sas_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign q_take      = (state_reg == ST_LOAD) && q_valid;
    assign room        = (count_reg != sas_pkg::CNT_W'(sas_pkg::CAPACITY));
    assign div_start   = (state_reg == ST_START);
    assign empty       = (state_reg != ST_EMIT);
    assign sorted_age  = head_age;
    assign mean_age    = mean_reg;
    assign min_age     = min_reg;
    assign max_age     = max_reg;
    assign above_count = above_reg;
    assign below_count = below_reg;
    assign dropped     = overflow_reg;
    assign end_of_run  = (count_reg == sas_pkg::CNT_W'(1));

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        overflow_next = overflow_reg;
        min_next      = min_reg;
        max_next      = max_reg;
        mean_next     = mean_reg;
        above_next    = above_reg;
        below_next    = below_reg;
        idx_next      = idx_reg;
        op            = '0;
        op.key        = q_item.age;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (q_valid)
                begin
                    if (room)
                    begin
                        op.insert  = 1'b1;
                        count_next = count_reg + sas_pkg::CNT_W'(1);
                        sum_next   = sum_reg + sas_pkg::SUM_W'(q_item.age);
                        if (count_reg == '0 || q_item.age < min_reg)
                        begin
                            min_next = q_item.age;
                        end
                        if (count_reg == '0 || q_item.age > max_reg)
                        begin
                            max_next = q_item.age;
                        end
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                    if (q_item.final_age)
                    begin
                        state_next = ST_START;
                    end
                end
            end
            ST_START:
            begin
                above_next = '0;
                below_next = '0;
                idx_next   = '0;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    mean_next  = div_quotient[sas_pkg::AGE_W-1:0];
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                // One full turn of the chain brings every age past the head once.
                op.rotate = 1'b1;
                if (head_valid && head_age > mean_reg)
                begin
                    above_next = above_reg + sas_pkg::CNT_W'(1);
                end
                else if (head_valid && head_age < mean_reg)
                begin
                    below_next = below_reg + sas_pkg::CNT_W'(1);
                end
                idx_next = idx_reg + sas_pkg::IDX_W'(1);
                if (idx_reg == sas_pkg::IDX_W'(sas_pkg::CAPACITY - 1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (pop)
                begin
                    op.pop     = 1'b1;
                    count_next = count_reg - sas_pkg::CNT_W'(1);
                    if (end_of_run)
                    begin
                        sum_next      = '0;
                        overflow_next = 1'b0;
                        state_next    = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            sum_reg      <= '0;
            overflow_reg <= 1'b0;
            idx_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            overflow_reg <= overflow_next;
            idx_reg      <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        min_reg   <= min_next;
        max_reg   <= max_next;
        mean_reg  <= mean_next;
        above_reg <= above_next;
        below_reg <= below_next;
    end

endmodule

>>> rtl/sorted_age_statistics_core.sv
// Top level of the sorted age statistics core: input queue, sort back end, checks.
// Loading takes one item per cycle while full is low; each age is placed by a parallel
// insertion chain. After the final item: a setup state, the SUM_W (14) bit divider for
// the mean and a full turn of the CAPACITY (64) cell chain to count ages above and below
// it, then one result per cycle while pop is held, popped from the chain head. Reset is
// asynchronous, active low, and clears the queue, the chain valid bits and all set state.
`include "sorted_age_statistics_core_defines.svh"
module sorted_age_statistics_core
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  sas_pkg::age_t age,
    input  logic          final_age,
    output logic          empty,
    input  logic          pop,
    output sas_pkg::age_t sorted_age,
    output sas_pkg::age_t mean_age,
    output sas_pkg::age_t min_age,
    output sas_pkg::age_t max_age,
    output sas_pkg::cnt_t above_count,
    output sas_pkg::cnt_t below_count,
    output logic          dropped,
    output logic          end_of_run
);

    sas_pkg::queue_item_t in_item;
    sas_pkg::queue_item_t q_item;
    logic                 q_valid;
    logic                 q_take;

    assign in_item.age       = age;
    assign in_item.final_age = final_age;

    sas_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .out_valid (q_valid),
        .out_item  (q_item),
        .take      (q_take)
    );

    sas_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_take      (q_take),
        .empty       (empty),
        .pop         (pop),
        .sorted_age  (sorted_age),
        .mean_age    (mean_age),
        .min_age     (min_age),
        .max_age     (max_age),
        .above_count (above_count),
        .below_count (below_count),
        .dropped     (dropped),
        .end_of_run  (end_of_run)
    );

    `SAS_ASSERT_HOLDS(a_mean_in_range, empty || (min_age <= mean_age && mean_age <= max_age))
    `SAS_ASSERT_HOLDS(a_age_in_range, empty || (min_age <= sorted_age && sorted_age <= max_age))
    `SAS_ASSERT_NEXT(a_last_pop_ends_run, !empty && pop && end_of_run, empty)
    `SAS_ASSERT_NEXT(a_mid_pop_continues, !empty && pop && !end_of_run, !empty)

endmodule

>>> verif/tb_sorted_age_statistics_core.sv
// Testbench for sorted_age_statistics_core: directed and random age sets checked against a scoreboard.
module tb_sorted_age_statistics_core;

    typedef struct {
        sas_pkg::age_t sorted;
        sas_pkg::age_t mean;
        sas_pkg::age_t lo;
        sas_pkg::age_t hi;
        sas_pkg::cnt_t above;
        sas_pkg::cnt_t below;
        logic          dropped;
        logic          end_mark;
    } age_report_t;

    class age_scoreboard;
        sas_pkg::age_t held [sas_pkg::CAPACITY];
        int            held_n;
        int            age_sum;
        bit            overflow;
        age_report_t   expected_q [$];
        int            errors;

        // Ages are kept in ascending order as they arrive, like the insertion chain.
        function void note_item(sas_pkg::age_t a, logic f);
            int          pos;
            int          mean_v;
            int          above_n;
            int          below_n;
            age_report_t r;
            if (held_n < sas_pkg::CAPACITY)
            begin
                pos = held_n;
                while (pos > 0 && held[pos-1] > a)
                begin
                    held[pos] = held[pos-1];
                    pos--;
                end
                held[pos] = a;
                held_n++;
                age_sum += a;
            end
            else
            begin
                overflow = 1;
            end
            if (!f)
                return;
            if (held_n > 0)
            begin
                mean_v  = age_sum / held_n;
                above_n = 0;
                below_n = 0;
                for (int i = 0; i < held_n; i++)
                begin
                    if (held[i] > mean_v)
                        above_n++;
                    else if (held[i] < mean_v)
                        below_n++;
                end
                for (int i = 0; i < held_n; i++)
                begin
                    r.sorted   = held[i];
                    r.mean     = sas_pkg::age_t'(mean_v);
                    r.lo       = held[0];
                    r.hi       = held[held_n-1];
                    r.above    = sas_pkg::cnt_t'(above_n);
                    r.below    = sas_pkg::cnt_t'(below_n);
                    r.dropped  = overflow;
                    r.end_mark = (i == held_n - 1);
                    expected_q.push_back(r);
                end
            end
            held_n   = 0;
            age_sum  = 0;
            overflow = 0;
        endfunction

        function void compare_field(string label, logic [7:0] want, logic [7:0] got);
            if (want !== got)
            begin
                $display("%0t: %s expected %0d, actual %0d", $time, label, want, got);
                errors++;
            end
        endfunction

        function void check_result(age_report_t got);
            age_report_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual sorted_age %0d",
                         $time, got.sorted);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("sorted_age", want.sorted, got.sorted);
            compare_field("mean_age", want.mean, got.mean);
            compare_field("min_age", want.lo, got.lo);
            compare_field("max_age", want.hi, got.hi);
            compare_field("above_count", want.above, got.above);
            compare_field("below_count", want.below, got.below);
            compare_field("dropped", want.dropped, got.dropped);
            compare_field("end_of_run", want.end_mark, got.end_mark);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic          clk = 1'b0;
    logic          rst_n;
    logic          push;
    logic          full;
    sas_pkg::age_t age;
    logic          final_age;
    logic          empty;
    logic          pop;
    sas_pkg::age_t sorted_age;
    sas_pkg::age_t mean_age;
    sas_pkg::age_t min_age;
    sas_pkg::age_t max_age;
    sas_pkg::cnt_t above_count;
    sas_pkg::cnt_t below_count;
    logic          dropped;
    logic          end_of_run;

    age_scoreboard sb = new;
    bit quiet = 1'b0;
    bit driving = 1'b0;

    // Sets of the directed part: single extremes, all equal, ties with the mean, descending.
    sas_pkg::age_t dir_ages [20] = '{0, 255, 10, 10, 10, 0, 255, 255, 0, 128, 64, 200,
                                     3, 1, 2, 200, 199, 198, 197, 196};
    bit            dir_last [20] = '{1, 1, 0, 0, 1, 0, 1, 0, 0, 0, 0, 1,
                                     0, 0, 1, 0, 0, 0, 0, 1};

    sorted_age_statistics_core dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .age         (age),
        .final_age   (final_age),
        .empty       (empty),
        .pop         (pop),
        .sorted_age  (sorted_age),
        .mean_age    (mean_age),
        .min_age     (min_age),
        .max_age     (max_age),
        .above_count (above_count),
        .below_count (below_count),
        .dropped     (dropped),
        .end_of_run  (end_of_run)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        age_report_t got;
        if (rst_n && push && !full)
            sb.note_item(age, final_age);
        if (rst_n && pop && !empty)
        begin
            got.sorted   = sorted_age;
            got.mean     = mean_age;
            got.lo       = min_age;
            got.hi       = max_age;
            got.above    = above_count;
            got.below    = below_count;
            got.dropped  = dropped;
            got.end_mark = end_of_run;
            sb.check_result(got);
        end
    end

    task automatic lower_push();
        if (driving)
        begin
            push    <= 1'b0;
            driving = 1'b0;
        end
    endtask

    task automatic send_age(input sas_pkg::age_t a, input logic f);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            lower_push();
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        push      <= 1'b1;
        driving   = 1'b1;
        age       <= a;
        final_age <= f;
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic wait_drained();
        lower_push();
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // The receiver stalls in random bursts until the closing stretch of the run.
    initial
    begin
        int stall;
        stall = 0;
        pop <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall > 0)
                stall--;
            else if (!quiet && $urandom_range(0, 7) == 0)
                stall = $urandom_range(1, 11);
            pop <= (stall == 0);
        end
    end

    initial
    begin
        int            sent;
        int            set_idx;
        int            set_len;
        int            base;
        int            pick;
        bit            narrow;
        sas_pkg::age_t a;
        push      <= 1'b0;
        age       <= '0;
        final_age <= 1'b0;
        rst_n     <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 20; i++)
            send_age(dir_ages[i], dir_last[i]);
        wait_drained();

        // Mostly short sets; one exactly full set, one that overflows, a few large ones.
        sent    = 0;
        set_idx = 0;
        while (sent < 300)
        begin
            if (set_idx == 2)
                set_len = sas_pkg::CAPACITY;
            else if (set_idx == 5)
                set_len = sas_pkg::CAPACITY + $urandom_range(1, 8);
            else if ($urandom_range(0, 9) == 0)
                set_len = $urandom_range(sas_pkg::CAPACITY - 8, sas_pkg::CAPACITY + 8);
            else
                set_len = $urandom_range(1, 10);
            narrow = ($urandom_range(0, 2) == 0);
            base   = $urandom_range(0, 252);
            for (int j = 0; j < set_len; j++)
            begin
                if (narrow)
                    a = sas_pkg::age_t'(base + $urandom_range(0, 3));
                else
                begin
                    pick = $urandom_range(0, 15);
                    if (pick == 0)
                        a = 8'd0;
                    else if (pick == 1)
                        a = 8'd255;
                    else
                        a = sas_pkg::age_t'($urandom_range(0, 255));
                end
                send_age(a, j == set_len - 1);
                sent++;
                if (sent > 260)
                    quiet = 1'b1;
            end
            if (set_idx == 3)
                wait_drained();
            set_idx++;
        end

        wait_drained();
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
